### rtl/brc_pkg.sv
package brc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned ADDR_W = 5;

   // width of both long dividers, tied to the 32-bit datapath
   localparam int unsigned DIV_W = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;

   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic        [15:0] ac4;
      logic        [15:0] ac5;
      logic        [15:0] ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
   } cal_type;

   // carried alongside the temperature divider
   typedef struct packed {
      logic signed [31:0] x1;
      logic        [15:0] up;
      logic               err;
      logic               qneg;
   } d1_side_type;

   // carried alongside the pressure divider
   typedef struct packed {
      logic signed [15:0] t;
      logic               err;
      logic               big;
   } d2_side_type;

   // signed divide by 2**k, truncating toward zero
   function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] v,
                                                  input int unsigned k);
      logic signed [31:0] bias;
      bias = (32'sd1 <<< k) - 32'sd1;
      return v[31] ? ((v + bias) >>> k) : (v >>> k);
   endfunction

endpackage

### rtl/brc_csr.sv
module brc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [brc_pkg::ADDR_W-1:0]   paddr,
   input  logic [brc_pkg::DATA_W-1:0]   pwdata,
   output logic [brc_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output brc_pkg::cal_type             cal
);

   logic [31:0] r0_ff, r1_ff, r2_ff, r3_ff, r4_ff;
   logic        wr;
   logic [2:0]  idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff <= '0;
         r1_ff <= '0;
         r2_ff <= '0;
         r3_ff <= '0;
         r4_ff <= '0;
      end else if (wr) begin
         case (idx)
            brc_pkg::REG_AC1_AC2: r0_ff <= pwdata;
            brc_pkg::REG_AC3_AC4: r1_ff <= pwdata;
            brc_pkg::REG_AC5_AC6: r2_ff <= pwdata;
            brc_pkg::REG_B1_B2:   r3_ff <= pwdata;
            brc_pkg::REG_MC_MD:   r4_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         brc_pkg::REG_AC1_AC2: prdata = r0_ff;
         brc_pkg::REG_AC3_AC4: prdata = r1_ff;
         brc_pkg::REG_AC5_AC6: prdata = r2_ff;
         brc_pkg::REG_B1_B2:   prdata = r3_ff;
         brc_pkg::REG_MC_MD:   prdata = r4_ff;
         default:              prdata = '0;
      endcase
   end

   assign cal.ac1 = r0_ff[31:16];
   assign cal.ac2 = r0_ff[15:0];
   assign cal.ac3 = r1_ff[31:16];
   assign cal.ac4 = r1_ff[15:0];
   assign cal.ac5 = r2_ff[31:16];
   assign cal.ac6 = r2_ff[15:0];
   assign cal.b1  = r3_ff[31:16];
   assign cal.b2  = r3_ff[15:0];
   assign cal.mc  = r4_ff[31:16];
   assign cal.md  = r4_ff[15:0];

endmodule

### rtl/brc_udiv.sv
// Unsigned restoring divider, one quotient bit per pipeline stage.
module brc_udiv #(
   parameter int unsigned W  = 32,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [W-1:0]  num,
   input  logic [W-1:0]  den,
   input  logic [SW-1:0] side,
   output logic          out_valid,
   output logic [W-1:0]  quo,
   output logic [SW-1:0] side_out
);

   logic          v_ff    [W];
   logic [W-1:0]  rem_ff  [W];
   logic [W-1:0]  nq_ff   [W];
   logic [W-1:0]  den_ff  [W];
   logic [SW-1:0] sd_ff   [W];
   logic [W-1:0]  rem_in  [W];
   logic [W-1:0]  nq_in   [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [W-1:0] src_rem, src_nq, src_den;
      logic [W:0]   sh;
      logic [W+1:0] diff;

      assign src_rem = (k == 0) ? '0  : rem_ff[(k == 0) ? 0 : k-1];
      assign src_nq  = (k == 0) ? num : nq_ff[(k == 0) ? 0 : k-1];
      assign src_den = (k == 0) ? den : den_ff[(k == 0) ? 0 : k-1];
      assign sh      = {src_rem, src_nq[W-1]};
      assign diff    = {1'b0, sh} - {2'b00, src_den};

      always_comb begin
         if (!diff[W+1]) begin
            rem_in[k] = diff[W-1:0];
            nq_in[k]  = {src_nq[W-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[W-1:0];
            nq_in[k]  = {src_nq[W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
         end
         if (en) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
            den_ff[k] <= src_den;
            sd_ff[k]  <= (k == 0) ? side : sd_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign out_valid = v_ff[W-1];
   assign quo       = nq_ff[W-1];
   assign side_out  = sd_ff[W-1];

endmodule

### rtl/barometer_reading_compensation.sv
// Barometric reading compensation, oversampling setting zero.
// Input channel (req_): one raw temperature word and one raw pressure word
// per item. Result channel (rsp_): temperature in 0.1 degC (saturated),
// pressure in Pa (clamped to 0..262143) and a divide-error flag; on a zero
// divisor both values read zero and the flag is set.
// Calibration: five packed 32-bit registers behind the APB port at byte
// addresses 0x00..0x10; write them only while no item is in flight.
// Pipeline: two 32-stage bit-per-stage dividers plus nine arithmetic stages.
// Throughput: one item per cycle. All stages advance together on a common
// enable; when the receiver holds rsp_ready low with a result waiting, the
// whole pipe freezes and req_ready drops, nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and sets every
// calibration register to zero.
module barometer_reading_compensation (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [15:0]                req_raw_temperature,
   input  logic [15:0]                req_raw_pressure,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [15:0]         rsp_temperature_tenths,
   output logic [17:0]                rsp_pressure_pa,
   output logic                       rsp_divide_error,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [brc_pkg::ADDR_W-1:0] paddr,
   input  logic [brc_pkg::DATA_W-1:0] pwdata,
   output logic [brc_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   brc_pkg::cal_type cal;
   logic en;

   brc_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cal
   );

   // one enable for the whole pipe: move unless a result is stuck at the port
   assign en        = rsp_ready | ~rsp_valid;
   assign req_ready = en;

   // ---- S1: x1 = (ut - ac6) * ac5 / 2^15, d = x1 + md
   logic signed [16:0] s1_diff;
   logic signed [33:0] s1_prod;
   logic signed [31:0] s1_x1;
   logic               s1_v_ff;
   logic signed [31:0] s1_x1_ff, s1_d_ff;
   logic [15:0]        s1_up_ff;

   assign s1_diff = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, cal.ac6});
   assign s1_prod = 34'(s1_diff) * $signed({18'b0, cal.ac5});
   assign s1_x1   = brc_pkg::sdiv_p2(s1_prod[31:0], 15);

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= req_valid;
      if (en) begin
         s1_x1_ff <= s1_x1;
         s1_d_ff  <= s1_x1 + 32'(cal.md);
         s1_up_ff <= req_raw_pressure;
      end
   end

   // ---- temperature divider: x2 = mc * 2048 / d, by magnitudes
   logic signed [31:0]             d1_num_s;
   logic [brc_pkg::DIV_W-1:0]      d1_num, d1_den, d1_quo;
   brc_pkg::d1_side_type           d1_side, d1_side_out;
   logic                           d1_v;

   assign d1_num_s     = 32'(cal.mc) <<< 11;
   assign d1_num       = brc_pkg::DIV_W'(d1_num_s[31] ? -d1_num_s : d1_num_s);
   assign d1_den       = brc_pkg::DIV_W'(s1_d_ff[31] ? -s1_d_ff : s1_d_ff);
   assign d1_side.x1   = s1_x1_ff;
   assign d1_side.up   = s1_up_ff;
   assign d1_side.err  = (s1_d_ff == '0);
   assign d1_side.qneg = d1_num_s[31] ^ s1_d_ff[31];

   brc_udiv #(.W(brc_pkg::DIV_W), .SW($bits(brc_pkg::d1_side_type))) u_div_t (
      .clock, .reset, .en, .in_valid(s1_v_ff), .num(d1_num), .den(d1_den),
      .side(d1_side), .out_valid(d1_v), .quo(d1_quo), .side_out(d1_side_out)
   );

   // ---- S3: b5, temperature, b6
   logic signed [31:0] s3_x2, s3_b5, s3_t;
   logic               s3_v_ff, s3_err_ff;
   logic signed [15:0] s3_t_ff;
   logic signed [31:0] s3_b6_ff;
   logic [15:0]        s3_up_ff;

   assign s3_x2 = d1_side_out.qneg ? -32'(d1_quo) : 32'(d1_quo);
   assign s3_b5 = d1_side_out.x1 + s3_x2;
   assign s3_t  = brc_pkg::sdiv_p2(s3_b5 + 32'sd8, 4);

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (en) s3_v_ff <= d1_v;
      if (en) begin
         if (s3_t > 32'sd32767)       s3_t_ff <= 16'sh7FFF;
         else if (s3_t < -32'sd32768) s3_t_ff <= 16'sh8000;
         else                         s3_t_ff <= s3_t[15:0];
         s3_b6_ff  <= s3_b5 - 32'sd4000;
         s3_up_ff  <= d1_side_out.up;
         s3_err_ff <= d1_side_out.err;
      end
   end

   // ---- S4: sq = b6^2 / 2^12, ac2*b6 / 2^11, ac3*b6 / 2^13
   logic signed [63:0] s4_sq, s4_a2, s4_a3;
   logic               s4_v_ff, s4_err_ff;
   logic signed [31:0] s4_sq_ff, s4_x2_ff, s4_x1c_ff;
   logic signed [15:0] s4_t_ff;
   logic [15:0]        s4_up_ff;

   assign s4_sq = s3_b6_ff * s3_b6_ff;
   assign s4_a2 = 64'(cal.ac2) * 64'(s3_b6_ff);
   assign s4_a3 = 64'(cal.ac3) * 64'(s3_b6_ff);

   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (en) s4_v_ff <= s3_v_ff;
      if (en) begin
         s4_sq_ff  <= brc_pkg::sdiv_p2(s4_sq[31:0], 12);
         s4_x2_ff  <= brc_pkg::sdiv_p2(s4_a2[31:0], 11);
         s4_x1c_ff <= brc_pkg::sdiv_p2(s4_a3[31:0], 13);
         s4_t_ff   <= s3_t_ff;
         s4_up_ff  <= s3_up_ff;
         s4_err_ff <= s3_err_ff;
      end
   end

   // ---- S5: b2*sq / 2^11, b1*sq / 2^16
   logic signed [63:0] s5_m1, s5_m2;
   logic               s5_v_ff, s5_err_ff;
   logic signed [31:0] s5_x1_ff, s5_x2_ff, s5_x1c_ff, s5_x2b_ff;
   logic signed [15:0] s5_t_ff;
   logic [15:0]        s5_up_ff;

   assign s5_m1 = 64'(cal.b2) * 64'(s4_sq_ff);
   assign s5_m2 = 64'(cal.b1) * 64'(s4_sq_ff);

   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (en) s5_v_ff <= s4_v_ff;
      if (en) begin
         s5_x1_ff  <= brc_pkg::sdiv_p2(s5_m1[31:0], 11);
         s5_x2b_ff <= brc_pkg::sdiv_p2(s5_m2[31:0], 16);
         s5_x2_ff  <= s4_x2_ff;
         s5_x1c_ff <= s4_x1c_ff;
         s5_t_ff   <= s4_t_ff;
         s5_up_ff  <= s4_up_ff;
         s5_err_ff <= s4_err_ff;
      end
   end

   // ---- S6: b3 and x3 + 32768
   logic signed [31:0] s6_b3sum, s6_x3sum, s6_x3;
   logic               s6_v_ff, s6_err_ff;
   logic signed [31:0] s6_b3_ff, s6_x3p_ff;
   logic signed [15:0] s6_t_ff;
   logic [15:0]        s6_up_ff;

   assign s6_b3sum = (32'(cal.ac1) <<< 2) + s5_x1_ff + s5_x2_ff + 32'sd2;
   assign s6_x3sum = s5_x1c_ff + s5_x2b_ff + 32'sd2;
   assign s6_x3    = brc_pkg::sdiv_p2(s6_x3sum, 2);

   always_ff @(posedge clock) begin
      if (reset) s6_v_ff <= 1'b0;
      else if (en) s6_v_ff <= s5_v_ff;
      if (en) begin
         s6_b3_ff  <= brc_pkg::sdiv_p2(s6_b3sum, 2);
         s6_x3p_ff <= s6_x3 + 32'sd32768;
         s6_t_ff   <= s5_t_ff;
         s6_up_ff  <= s5_up_ff;
         s6_err_ff <= s5_err_ff;
      end
   end

   // ---- S7: b4 = ac4 * (x3 + 32768) / 2^15, b7 = (up - b3) * 50000
   logic [47:0] s7_b4p, s7_b7p;
   logic [31:0] s7_upd;
   logic        s7_v_ff, s7_err_ff;
   logic [16:0] s7_b4_ff;
   logic [31:0] s7_b7_ff;
   logic signed [15:0] s7_t_ff;

   assign s7_b4p = 48'(cal.ac4) * 48'(unsigned'(s6_x3p_ff));
   assign s7_upd = 32'(s6_up_ff) - unsigned'(s6_b3_ff);
   assign s7_b7p = 48'(s7_upd) * 48'd50000;

   always_ff @(posedge clock) begin
      if (reset) s7_v_ff <= 1'b0;
      else if (en) s7_v_ff <= s6_v_ff;
      if (en) begin
         s7_b4_ff  <= s7_b4p[31:15];
         s7_b7_ff  <= s7_b7p[31:0];
         s7_t_ff   <= s6_t_ff;
         s7_err_ff <= s6_err_ff;
      end
   end

   // ---- pressure divider: b7*2/b4 or (b7/b4)*2 when b7 has its top bit set
   logic [brc_pkg::DIV_W-1:0] d2_num, d2_den, d2_quo;
   brc_pkg::d2_side_type      d2_side, d2_side_out;
   logic                      d2_v;

   assign d2_num = brc_pkg::DIV_W'(s7_b7_ff[31] ? s7_b7_ff : {s7_b7_ff[30:0], 1'b0});
   assign d2_den      = brc_pkg::DIV_W'(s7_b4_ff);
   assign d2_side.t   = s7_t_ff;
   assign d2_side.err = s7_err_ff | (s7_b4_ff == '0);
   assign d2_side.big = s7_b7_ff[31];

   brc_udiv #(.W(brc_pkg::DIV_W), .SW($bits(brc_pkg::d2_side_type))) u_div_p (
      .clock, .reset, .en, .in_valid(s7_v_ff), .num(d2_num), .den(d2_den),
      .side(d2_side), .out_valid(d2_v), .quo(d2_quo), .side_out(d2_side_out)
   );

   // ---- S8: (p/256)^2 and -7357*p / 2^16
   logic [31:0]        s8_q32;
   logic signed [31:0] s8_p, s8_pd;
   logic signed [63:0] s8_sq, s8_m;
   logic               s8_v_ff, s8_err_ff;
   logic signed [31:0] s8_p_ff, s8_sq_ff, s8_x2_ff;
   logic signed [15:0] s8_t_ff;

   assign s8_q32 = d2_quo[31:0];
   assign s8_p   = d2_side_out.big ? signed'({s8_q32[30:0], 1'b0}) : signed'(s8_q32);
   assign s8_pd  = brc_pkg::sdiv_p2(s8_p, 8);
   assign s8_sq  = 64'(s8_pd) * 64'(s8_pd);
   assign s8_m   = 64'(s8_p) * -64'sd7357;

   always_ff @(posedge clock) begin
      if (reset) s8_v_ff <= 1'b0;
      else if (en) s8_v_ff <= d2_v;
      if (en) begin
         s8_p_ff   <= s8_p;
         s8_sq_ff  <= s8_sq[31:0];
         s8_x2_ff  <= brc_pkg::sdiv_p2(s8_m[31:0], 16);
         s8_t_ff   <= d2_side_out.t;
         s8_err_ff <= d2_side_out.err;
      end
   end

   // ---- S9: x1 = sq * 3038 / 2^16
   logic signed [63:0] s9_m;
   logic               s9_v_ff, s9_err_ff;
   logic signed [31:0] s9_p_ff, s9_x1_ff, s9_x2_ff;
   logic signed [15:0] s9_t_ff;

   assign s9_m = 64'(s8_sq_ff) * 64'sd3038;

   always_ff @(posedge clock) begin
      if (reset) s9_v_ff <= 1'b0;
      else if (en) s9_v_ff <= s8_v_ff;
      if (en) begin
         s9_x1_ff  <= brc_pkg::sdiv_p2(s9_m[31:0], 16);
         s9_x2_ff  <= s8_x2_ff;
         s9_p_ff   <= s8_p_ff;
         s9_t_ff   <= s8_t_ff;
         s9_err_ff <= s8_err_ff;
      end
   end

   // ---- S10: final correction, clamp, output register
   logic signed [31:0] s10_pf;
   logic               out_v_ff, out_err_ff;
   logic signed [15:0] out_t_ff;
   logic [17:0]        out_p_ff;

   assign s10_pf = s9_p_ff
                 + brc_pkg::sdiv_p2(s9_x1_ff + s9_x2_ff + 32'sd3791, 4);

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= s9_v_ff;
      if (en) begin
         out_err_ff <= s9_err_ff;
         if (s9_err_ff) begin
            out_t_ff <= '0;
            out_p_ff <= '0;
         end else begin
            out_t_ff <= s9_t_ff;
            if (s10_pf[31])                  out_p_ff <= '0;
            else if (s10_pf > 32'sd262143)   out_p_ff <= '1;
            else                             out_p_ff <= s10_pf[17:0];
         end
      end
   end

   assign rsp_valid              = out_v_ff;
   assign rsp_temperature_tenths = out_t_ff;
   assign rsp_pressure_pa        = out_p_ff;
   assign rsp_divide_error       = out_err_ff;

endmodule

### rtl/brc_checker.sv
module brc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_temperature_tenths,
   input logic [17:0]        rsp_pressure_pa,
   input logic               rsp_divide_error
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature_tenths)
         && $stable(rsp_pressure_pa) && $stable(rsp_divide_error))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_temperature_tenths == '0
         && rsp_pressure_pa == '0)
      else $error("divide error with nonzero outputs");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while pipe frozen");

endmodule

bind barometer_reading_compensation brc_checker u_brc_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_temperature_tenths, .rsp_pressure_pa, .rsp_divide_error
);

### bench/testbench.sv
module testbench;

   // pipe depth from the block's header; used for the drain after the last item
   localparam int PIPE_LAT  = 73;
   localparam int CYCLE_CAP = 400000;
   localparam int HOLD_LEN  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_raw_temperature = '0;
   logic [15:0] req_raw_pressure = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [15:0] rsp_temperature_tenths;
   logic [17:0] rsp_pressure_pa;
   logic        rsp_divide_error;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [brc_pkg::ADDR_W-1:0] paddr = '0;
   logic [brc_pkg::DATA_W-1:0] pwdata = '0;
   logic [brc_pkg::DATA_W-1:0] prdata;
   logic        pready;

   barometer_reading_compensation u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_raw_temperature(req_raw_temperature), .req_raw_pressure(req_raw_pressure),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_temperature_tenths(rsp_temperature_tenths),
      .rsp_pressure_pa(rsp_pressure_pa), .rsp_divide_error(rsp_divide_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // one compensated reading
   typedef struct {
      logic signed [15:0] temp;
      logic [17:0]        press;
      logic               err;
   } reading_type;

   reading_type pending_readings[$];
   logic [31:0] cal_regs[5];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          sink_idle_on = 1'b1;   // random stalls on the result side
   bit          src_idle_on = 1'b1;    // random gaps on the input side
   int          hold_req = 0;          // bumped to ask for a long hold-off
   int          hold_seen = 0;
   int          hold_cycles = 0;       // hold-off cycles still to go

   task automatic report(input string what);
      $display("mismatch @%0d: %s", cycle_count, what);
      fail_count++;
   endtask

   // -------------------------------------------------------------------
   // Compensation predictor: 32-bit wrapping arithmetic, truncating
   // division, unsigned B4/B7.
   // -------------------------------------------------------------------
   function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      // most-negative / -1 wraps back to most-negative
      if (b == -32'sd1) return -a;
      return a / b;
   endfunction

   function automatic reading_type compensate(input logic [15:0] ut_raw,
                                              input logic [15:0] up_raw);
      reading_type r;
      logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
      logic signed [31:0] x1, x2, x3, b5, b6, b3, t, p, sq, d;
      logic [31:0] ac4, up, b4, b7, pu;
      ac1 = 32'(signed'(cal_regs[brc_pkg::REG_AC1_AC2][31:16]));
      ac2 = 32'(signed'(cal_regs[brc_pkg::REG_AC1_AC2][15:0]));
      ac3 = 32'(signed'(cal_regs[brc_pkg::REG_AC3_AC4][31:16]));
      ac4 = {16'd0, cal_regs[brc_pkg::REG_AC3_AC4][15:0]};
      ac5 = {16'd0, cal_regs[brc_pkg::REG_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_regs[brc_pkg::REG_AC5_AC6][15:0]};
      b1  = 32'(signed'(cal_regs[brc_pkg::REG_B1_B2][31:16]));
      b2  = 32'(signed'(cal_regs[brc_pkg::REG_B1_B2][15:0]));
      mc  = 32'(signed'(cal_regs[brc_pkg::REG_MC_MD][31:16]));
      md  = 32'(signed'(cal_regs[brc_pkg::REG_MC_MD][15:0]));
      ut  = {16'd0, ut_raw};
      up  = {16'd0, up_raw};
      r.temp = '0; r.press = '0; r.err = 1'b1;

      x1 = ((ut - ac6) * ac5) / 32'sd32768;
      d = x1 + md;
      if (d == 0) return r;
      x2 = tdiv(mc * 32'sd2048, d);
      b5 = x1 + x2;
      t = (b5 + 32'sd8) / 32'sd16;

      b6 = b5 - 32'sd4000;
      sq = (b6 * b6) / 32'sd4096;
      x1 = (b2 * sq) / 32'sd2048;
      x2 = (ac2 * b6) / 32'sd2048;
      x3 = x1 + x2;
      b3 = ((ac1 * 32'sd4) + x3 + 32'sd2) / 32'sd4;
      x1 = (ac3 * b6) / 32'sd8192;
      x2 = (b1 * sq) / 32'sd65536;
      x3 = (x1 + x2 + 32'sd2) / 32'sd4;
      b4 = (ac4 * 32'(x3 + 32'sd32768)) / 32'd32768;
      if (b4 == 0) return r;
      b7 = (up - 32'(b3)) * 32'd50000;
      if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
      else pu = (b7 / b4) * 32'd2;
      p = signed'(pu);

      x1 = (p / 32'sd256) * (p / 32'sd256);
      x1 = (x1 * 32'sd3038) / 32'sd65536;
      x2 = (-32'sd7357 * p) / 32'sd65536;
      p = p + (x1 + x2 + 32'sd3791) / 32'sd16;

      if (t > 32'sd32767) t = 32'sd32767;
      if (t < -32'sd32768) t = -32'sd32768;
      if (p < 0) p = 0;
      if (p > 32'sd262143) p = 32'sd262143;
      r.temp = t[15:0];
      r.press = p[17:0];
      r.err = 1'b0;
      return r;
   endfunction

   // -------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------
   // APB write: setup cycle, then access cycle; pready is tied high.
   // The bus is released by load_cal after the last write.
   task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= brc_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cal_regs[idx] = val;
   endtask

   // Present one item; the expectation is queued on the accepting edge.
   // Valid stays up after acceptance until an idle gap or a drain drops it.
   task automatic send_reading(input logic [15:0] ut, input logic [15:0] up);
      if (src_idle_on) begin
         while ($urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_raw_temperature <= ut;
      req_raw_pressure <= up;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_readings.push_back(compensate(ut, up));
   endtask

   // Wait for the pipe to empty so the calibration can change safely.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 8) @(posedge clock);
   endtask

   task automatic load_cal(input logic [31:0] r0, r1, r2, r3, r4);
      drain();
      write_cal(brc_pkg::REG_AC1_AC2, r0);
      write_cal(brc_pkg::REG_AC3_AC4, r1);
      write_cal(brc_pkg::REG_AC5_AC6, r2);
      write_cal(brc_pkg::REG_B1_B2, r3);
      write_cal(brc_pkg::REG_MC_MD, r4);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // typical datasheet-like calibration set
   task automatic load_typical;
      load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
               {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
               {-16'sd8711, 16'sd2868});
   endtask

   // -------------------------------------------------------------------
   // Result side: random stalls plus an optional long hold-off
   // -------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_cycles <= HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !sink_idle_on || ($urandom_range(99) >= 20);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            report("result with nothing outstanding");
         end else begin
            want = pending_readings.pop_front();
            if (rsp_temperature_tenths !== want.temp)
               report($sformatf("temperature %0d, want %0d",
                                rsp_temperature_tenths, want.temp));
            if (rsp_pressure_pa !== want.press)
               report($sformatf("pressure %0d, want %0d", rsp_pressure_pa, want.press));
            if (rsp_divide_error !== want.err)
               report($sformatf("divide error %0b, want %0b", rsp_divide_error, want.err));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_CAP) begin
         $display("testbench failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------
   // reset calibration is all zero: AC5 = 0 and MD = 0 give a zero divisor
   task automatic test_reset_calibration;
      send_reading(16'h0000, 16'h0000);
      send_reading(16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_directed;
      load_typical();
      send_reading(16'd27898, 16'd23843);
      send_reading(16'h0000, 16'h0000);
      send_reading(16'hFFFF, 16'hFFFF);
      send_reading(16'h8000, 16'h7FFF);
      send_reading(16'h7FFF, 16'h8000);
      send_reading(16'd23153, 16'd40000);   // UT equal to AC6
      // zero temperature divisor: AC5 = 0 leaves X1 = 0, MD = 0
      load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h0000_5A71, 32'h182E_0004, 32'hDDF9_0000);
      send_reading(16'd27898, 16'd23843);
      // zero pressure divisor: AC4 = 0
      load_cal(32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34);
      send_reading(16'd27898, 16'd23843);
      // temperature divisor of minus one: AC5 = 0, MD = -1, MC = -32768
      load_cal(32'h8000_7FFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_8000, 32'h8000_FFFF);
      send_reading(16'h0000, 16'hFFFF);
      send_reading(16'hFFFF, 16'h0000);
      // field extremes on every coefficient
      load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_FFFF, 32'h8000_7FFF, 32'h7FFF_7FFF);
      send_reading(16'h0000, 16'h0000);
      send_reading(16'hFFFF, 16'hFFFF);
      send_reading(16'h5555, 16'hAAAA);
      load_cal(32'h8000_7FFF, 32'h7FFF_0001, 32'h0001_0000, 32'h7FFF_8000, 32'h8000_8000);
      send_reading(16'hAAAA, 16'h5555);
      send_reading(16'hFFFF, 16'h0000);
   endtask

   // mostly realistic calibrations with random raw words, some wild sets
   task automatic test_random;
      int n;
      for (int blk = 0; blk < 10; blk++) begin
         if (blk % 3 == 2)
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
         else
            load_cal({16'($urandom_range(300, 9000)), 16'(-$urandom_range(0, 1500))},
                     {16'(-$urandom_range(5000, 16000)), 16'($urandom_range(25000, 40000))},
                     {16'($urandom_range(20000, 40000)), 16'($urandom_range(15000, 30000))},
                     {16'($urandom_range(3000, 9000)), 16'($urandom_range(0, 100))},
                     {16'(-$urandom_range(8000, 12000)), 16'($urandom_range(1500, 4000))});
         // no-idle stretch on the fourth block
         src_idle_on = (blk != 3);
         sink_idle_on = (blk != 3);
         n = 40;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
               send_reading(16'($urandom), 16'($urandom));
            else
               send_reading(16'($urandom_range(20000, 36000)),
                            16'($urandom_range(15000, 45000)));
         end
      end
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   // receiver holds off long enough for the pipe to fill and stall input
   task automatic test_backpressure;
      load_typical();
      hold_req++;
      for (int i = 0; i < 120; i++)
         send_reading(16'($urandom_range(20000, 36000)), 16'($urandom));
      // sender waits for every result before the next burst
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      for (int i = 0; i < 20; i++)
         send_reading(16'($urandom), 16'($urandom));
   endtask

   initial begin
      foreach (cal_regs[i]) cal_regs[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_calibration();
      test_directed();
      test_random();
      test_backpressure();
      drain();
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
